// ===== src/assert_macros.svh =====
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define MSG_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked property, checked during reset as well
`define MSG_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/msg_pkg.sv =====
// shared widths, reset values and codes of the motor speed governor
`default_nettype none

package msg_pkg;

    localparam int SpeedW = 16;
    localparam int DriveW = 16;
    localparam int CountW = 8;
    localparam int MaxW   = 14;
    localparam int GainW  = 15;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [SpeedW-1:0] STALL_SPEED_RST  = 16'd5;
    localparam logic [SpeedW-1:0] TARGET_SPEED_RST = 16'd17;
    localparam logic [MaxW-1:0]   MAX_DRIVE_RST    = 14'd8191;
    localparam logic [GainW-1:0]  GAIN_RST         = 15'd100;
    localparam logic [CountW-1:0] GIVE_UP_RST      = 8'd20;
    localparam logic [CountW-1:0] KICK_RST         = 8'd10;

    localparam logic CMD_THROTTLE_WRITE = 1'b0;
    localparam logic CMD_SPEED_READ     = 1'b1;

    typedef enum logic [2:0] {
        OUT_NONE      = 3'd0,
        OUT_STALL     = 3'd1,
        OUT_KICK      = 3'd2,
        OUT_GAVE_UP   = 3'd3,
        OUT_RESTART   = 3'd4,
        OUT_REGULATED = 3'd5,
        OUT_FAIL      = 3'd6
    } outcome_t;

    typedef enum logic [2:0] {
        REG_STALL_SPEED  = 3'd0,
        REG_TARGET_SPEED = 3'd1,
        REG_MAX_DRIVE    = 3'd2,
        REG_GAIN         = 3'd3,
        REG_GIVE_UP      = 3'd4,
        REG_KICK         = 3'd5
    } reg_idx_t;

endpackage

`default_nettype wire

// ===== src/motor_speed_governor.sv =====
// motor speed governor: throttle, start flag and stall count updated per transfer event
//
// Each transaction on the s_ side is one finished bus transfer (throttle write or
// speed read). The block keeps a signed 16-bit throttle, a started flag and a stall
// count, and for every transaction returns exactly one result on the m_ side: the
// state after the event, the two packed command bytes and an outcome code. One
// transaction is taken per clock while s_tready is high. An accepted transaction is
// held in the input register, which feeds the update logic with its 16x16 low-half
// multiply, which loads the result register. While a result waits downstream the input
// register still takes one more transaction, then s_tready drops until the result leaves.
// The state registers loop back through the update logic, so back-to-back events each
// see the state left by the one before. Registers sit on an APB-style port at byte
// addresses 4*i and should be written only while no event is in flight.
`default_nettype none

module motor_speed_governor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] measured_speed
    input  logic [msg_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] cmd, [1] transfer_ok
    input  logic [msg_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] drive_value, [23:16] drive_high_byte, [31:24] drive_low_byte,
    // [32] running, [40:33] stall_tally, [47:41] zero
    output logic [msg_pkg::M_TDATA_W-1:0]  m_tdata,
    // [2:0] outcome
    output logic [msg_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [msg_pkg::APB_AW-1:0]     paddr,
    input  logic [msg_pkg::APB_DW-1:0]     pwdata,
    output logic [msg_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    import msg_pkg::*;

    // configuration registers
    logic [SpeedW-1:0] stall_speed_reg;
    logic [SpeedW-1:0] target_speed_reg;
    logic [MaxW-1:0]   max_drive_reg;
    logic [GainW-1:0]  gain_reg;
    logic [CountW-1:0] give_up_reg;
    logic [CountW-1:0] kick_reg;

    // input stage
    logic              in_valid_reg;
    logic              in_cmd_reg;
    logic              in_ok_reg;
    logic [SpeedW-1:0] in_speed_reg;

    // governor state
    logic [DriveW-1:0] drive_reg;
    logic              started_reg;
    logic [CountW-1:0] stall_reg;

    // result stage
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    outcome_t             out_outcome_reg;

    logic              cfg_write;
    reg_idx_t          cfg_idx;
    logic              out_load;
    logic              in_load;

    logic [DriveW-1:0] drive_next;
    logic              started_next;
    logic [CountW-1:0] stall_next;
    outcome_t          outcome_next;
    logic [M_TDATA_W-1:0] out_data_next;

    logic [CountW-1:0] stall_inc;
    logic [SpeedW-1:0] speed_err;
    logic [DriveW-1:0] prod;
    logic [DriveW-1:0] drive_sub;
    logic [DriveW-1:0] max_ext;
    logic [DriveW-1:0] drive_clamped;

    // apb port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_STALL_SPEED:  prdata = APB_DW'(stall_speed_reg);
            REG_TARGET_SPEED: prdata = APB_DW'(target_speed_reg);
            REG_MAX_DRIVE:    prdata = APB_DW'(max_drive_reg);
            REG_GAIN:         prdata = APB_DW'(gain_reg);
            REG_GIVE_UP:      prdata = APB_DW'(give_up_reg);
            REG_KICK:         prdata = APB_DW'(kick_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stall_speed_reg  <= STALL_SPEED_RST;
            target_speed_reg <= TARGET_SPEED_RST;
            max_drive_reg    <= MAX_DRIVE_RST;
            gain_reg         <= GAIN_RST;
            give_up_reg      <= GIVE_UP_RST;
            kick_reg         <= KICK_RST;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_STALL_SPEED:  stall_speed_reg  <= pwdata[SpeedW-1:0];
                REG_TARGET_SPEED: target_speed_reg <= pwdata[SpeedW-1:0];
                REG_MAX_DRIVE:    max_drive_reg    <= pwdata[MaxW-1:0];
                REG_GAIN:         gain_reg         <= pwdata[GainW-1:0];
                REG_GIVE_UP:      give_up_reg      <= pwdata[CountW-1:0];
                REG_KICK:         kick_reg         <= pwdata[CountW-1:0];
                default: ;
            endcase
        end
    end

    // flow control: input register refills while a result waits downstream
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    // update logic, throttle arithmetic wraps at 16 bits and the stall count at 8 bits
    assign stall_inc = stall_reg + CountW'(1);
    assign speed_err = in_speed_reg - target_speed_reg;
    assign prod      = speed_err * {1'b0, gain_reg};
    assign drive_sub = drive_reg - prod;
    assign max_ext   = {{(DriveW-MaxW){1'b0}}, max_drive_reg};

    // upper clamp first, then lower, so a zero max ends at 1
    always_comb begin
        drive_clamped = drive_sub;
        if ($signed(drive_sub) > $signed(max_ext)) begin
            drive_clamped = max_ext;
        end
        if ($signed(drive_clamped) < $signed(DriveW'(1))) begin
            drive_clamped = DriveW'(1);
        end
    end

    always_comb begin
        drive_next   = drive_reg;
        started_next = started_reg;
        stall_next   = stall_reg;
        outcome_next = OUT_NONE;
        if (!in_ok_reg) begin
            outcome_next = OUT_FAIL;
        end else if (in_cmd_reg == CMD_THROTTLE_WRITE) begin
            if (drive_reg[DriveW-1] || drive_reg == '0) begin
                started_next = 1'b1;
            end
        end else if (started_reg) begin
            if (in_speed_reg < stall_speed_reg && drive_reg != '0) begin
                stall_next = stall_inc;
                if (stall_reg > give_up_reg) begin
                    drive_next   = '0;
                    started_next = 1'b0;
                    stall_next   = '0;
                    outcome_next = OUT_GAVE_UP;
                end else if (stall_inc > kick_reg) begin
                    drive_next   = drive_reg + max_ext;
                    outcome_next = OUT_KICK;
                end else begin
                    outcome_next = OUT_STALL;
                end
            end else if (drive_reg == '0) begin
                drive_next   = DriveW'(1);
                outcome_next = OUT_RESTART;
            end else begin
                drive_next   = drive_clamped;
                outcome_next = OUT_REGULATED;
            end
        end
    end

    assign out_data_next = {7'b0, stall_next, started_next,
                            drive_next[5:0], 2'b00, drive_next[13:6], drive_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
            started_reg   <= 1'b0;
            stall_reg     <= '0;
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
                drive_reg     <= drive_next;
                started_reg   <= started_next;
                stall_reg     <= stall_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_cmd_reg   <= s_tuser[0];
            in_ok_reg    <= s_tuser[1];
            in_speed_reg <= s_tdata[SpeedW-1:0];
        end
        if (out_load) begin
            out_data_reg    <= out_data_next;
            out_outcome_reg <= outcome_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_outcome_reg;

endmodule

`default_nettype wire

// ===== src/msg_checker.sv =====
// port-level checks of the motor speed governor, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module msg_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [msg_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [msg_pkg::M_TUSER_W-1:0]  m_tuser
);

    import msg_pkg::*;

    // a stalled result transaction holds
    `MSG_ASSERT_CLK(a_result_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // command bytes follow the throttle
    `MSG_ASSERT_CLK(a_bytes_match, aclk, aresetn, m_tvalid |-> m_tdata[23:16] == m_tdata[13:6] && m_tdata[31:26] == m_tdata[5:0] && m_tdata[25:24] == 2'b00, "command bytes disagree with throttle")

    // giving up clears throttle, start flag and stall count
    `MSG_ASSERT_CLK(a_gave_up_clear, aclk, aresetn, m_tvalid && m_tuser == OUT_GAVE_UP |-> m_tdata[15:0] == 16'd0 && !m_tdata[32] && m_tdata[40:33] == 8'd0, "give-up left state behind")

    // regulation and restart leave a positive throttle on a running motor
    `MSG_ASSERT_CLK(a_regulated_pos, aclk, aresetn, m_tvalid && (m_tuser == OUT_REGULATED || m_tuser == OUT_RESTART) |-> !m_tdata[15] && m_tdata[15:0] != 16'd0 && m_tdata[32], "regulated throttle not positive")

    // nothing is offered straight after reset
    `MSG_ASSERT_NORST(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind motor_speed_governor msg_checker u_msg_checker (.*);

`default_nettype wire
